/* design/seconds_to_calendar_alarm_top_macros.svh */
// Assertion macros for the checker of the calendar alarm converter.
// Depends on nothing; each file that asserts includes this header.
`ifndef SECONDS_TO_CALENDAR_ALARM_TOP_MACROS_SVH
`define SECONDS_TO_CALENDAR_ALARM_TOP_MACROS_SVH

// Concurrent implication with overlap, checked only outside reset.
`define SCA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Invariant that holds at every edge outside reset.
`define SCA_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: invariant check failed");

// Implication into the next cycle, checked during reset as well.
`define SCA_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* design/seccal_pkg.sv */
// Types, constants and helper functions for the calendar alarm converter.
// Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps

package seccal_pkg;

    // Field types of one transaction.
    typedef logic [31:0] t_secs;
    typedef logic [6:0]  t_minute_bcd;
    typedef logic [5:0]  t_hour_bcd;
    typedef logic [5:0]  t_day_bcd;
    typedef logic [3:0]  t_month;
    typedef logic [7:0]  t_year;

    // Calendar constants.
    localparam int unsigned SECS_PER_DAY   = 60 * 60 * 24;
    localparam int unsigned SECS_PER_HOUR  = 3600;
    localparam int unsigned DAYS_PER_CYCLE = 366 + 365 + 365 + 365;
    localparam int unsigned DAYS_LEAP      = 366;
    localparam int unsigned DAYS_COMMON    = 365;
    localparam int unsigned MONTH_FIRST    = 1;
    localparam int unsigned MONTH_LAST     = 12;

    // Reciprocals for the constant divisions. The day division runs on
    // seconds shifted right by 7 (86400 = 128 * 675) and may come out one low.
    localparam int unsigned DAY_SHIFT     = 7;
    localparam int unsigned DAY_DIV       = SECS_PER_DAY >> DAY_SHIFT;
    localparam int unsigned DAY_RECIP_K   = 34;
    localparam longint unsigned DAY_RECIP = (64'd1 << DAY_RECIP_K) / DAY_DIV;
    localparam int unsigned HOUR_RECIP_K  = 27;
    localparam int unsigned HOUR_RECIP    = ((1 << HOUR_RECIP_K) + SECS_PER_HOUR - 1)
                                            / SECS_PER_HOUR;
    localparam int unsigned CYC_RECIP_K   = 26;
    localparam int unsigned CYC_RECIP     = ((1 << CYC_RECIP_K) + DAYS_PER_CYCLE - 1)
                                            / DAYS_PER_CYCLE;
    localparam int unsigned MIN_RECIP_K   = 18;
    localparam int unsigned MIN_RECIP     = ((1 << MIN_RECIP_K) + 60 - 1) / 60;

    // First day of each month, counted from 0, for common and leap years.
    localparam logic [8:0] MONTH_START_COMMON [0:12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [8:0] MONTH_START_LEAP [0:12] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

    // Month start lookup for either kind of year.
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] v;
        v = leap ? MONTH_START_LEAP[idx] : MONTH_START_COMMON[idx];
        return v;
    endfunction

    // Two-digit packed BCD of a value below 100; tens come from v * 205 >> 11.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        ones = v - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

endpackage

/* design/seconds_to_calendar_alarm_top.sv */
// Top level of the calendar alarm converter: seconds since 2000 to alarm fields.
// Depends on seccal_pkg for field types, reciprocal constants and month tables.
// A transaction taken at an edge passes through the input register, five arithmetic
// stages and the result register; o_done is set as its result is registered. Throughput: one
// transaction per cycle; busy stays low.
// Reset (synchronous, active low) clears the stage valid bits and o_done.
`timescale 1ns / 1ps

module seconds_to_calendar_alarm_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  seccal_pkg::t_secs         i_seconds_since_2000,
    output logic                      o_done,
    output seccal_pkg::t_minute_bcd   o_minute_bcd,
    output seccal_pkg::t_hour_bcd     o_hour_bcd,
    output seccal_pkg::t_day_bcd      o_day_bcd,
    output seccal_pkg::t_month        o_month_number,
    output seccal_pkg::t_year         o_year_offset
);
    import seccal_pkg::*;

    // Stage valid bits: input register and five work stages.
    logic [5:0]  r_vld;

    // Stage 0: input register.
    t_secs       r_secs0;

    // Stage 1: day quotient estimate.
    t_secs       r_secs1;
    logic [15:0] r_q1;

    // Stage 2: exact day count and second of day.
    logic [15:0] r_days2;
    logic [16:0] r_sod2;

    // Stage 3: hour and four-year cycle count.
    logic [15:0] r_days3;
    logic [16:0] r_sod3;
    logic [4:0]  r_hour3;
    logic [5:0]  r_cyc3;

    // Stage 4: second of hour and day of cycle.
    logic [11:0] r_soh4;
    logic [10:0] r_doc4;
    logic [4:0]  r_hour4;
    logic [5:0]  r_cyc4;

    // Stage 5: minute, year and day of year.
    logic [5:0]  r_min5;
    logic [4:0]  r_hour5;
    t_year       r_year5;
    logic [8:0]  r_doy5;
    logic        r_leap5;

    // Combinational values between the stages.
    logic [49:0] n_prod1;
    logic [15:0] n_q1;
    logic [32:0] n_t2_wide;
    logic [17:0] n_t2;
    logic [15:0] n_days2;
    logic [16:0] n_sod2;
    logic [32:0] n_hprod3;
    logic [31:0] n_cprod3;
    logic [16:0] n_soh4_wide;
    logic [16:0] n_doc4_wide;
    logic [24:0] n_mprod5;
    logic [1:0]  n_yic5;
    logic [10:0] n_doy5_wide;
    logic        n_leap5;
    logic [3:0]  n_month6;
    logic [8:0]  n_base6;
    logic [8:0]  n_dom6_wide;
    logic [7:0]  n_min_bcd6;
    logic [7:0]  n_hour_bcd6;
    logic [7:0]  n_day_bcd6;

    // The pipeline never holds off a transaction.
    assign busy = 1'b0;

    // Valid bits and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            o_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[4:0], start & ~busy};
            o_done <= r_vld[5];
        end
    end

    // Stage 1: divide seconds by 86400 with a reciprocal of 675 on secs >> 7.
    always_comb begin
        n_prod1 = 50'(r_secs0[31:DAY_SHIFT]) * 50'(DAY_RECIP);
        n_q1    = n_prod1[49:DAY_RECIP_K];
    end

    // Stage 2: remainder and a single correction of the quotient.
    always_comb begin
        n_t2_wide = {1'b0, r_secs1} - 33'(r_q1) * 33'(SECS_PER_DAY);
        n_t2      = n_t2_wide[17:0];
        if (n_t2 >= 18'(SECS_PER_DAY)) begin
            n_days2 = r_q1 + 16'd1;
            n_sod2  = 17'(n_t2 - 18'(SECS_PER_DAY));
        end else begin
            n_days2 = r_q1;
            n_sod2  = n_t2[16:0];
        end
    end

    // Stage 3: hour of day and count of whole four-year cycles.
    always_comb begin
        n_hprod3 = 33'(r_sod2) * 33'(HOUR_RECIP);
        n_cprod3 = 32'(r_days2) * 32'(CYC_RECIP);
    end

    // Stage 4: leftovers after the hour and the cycle.
    always_comb begin
        n_soh4_wide = r_sod3 - 17'(r_hour3) * 17'(SECS_PER_HOUR);
        n_doc4_wide = 17'(r_days3) - 17'(r_cyc3) * 17'(DAYS_PER_CYCLE);
    end

    // Stage 5: minute of hour, year within the cycle and day of year.
    always_comb begin
        n_mprod5 = 25'(r_soh4) * 25'(MIN_RECIP);
        if (r_doc4 < 11'(DAYS_LEAP)) begin
            n_yic5      = 2'd0;
            n_doy5_wide = r_doc4;
            n_leap5     = 1'b1;
        end else if (r_doc4 < 11'(DAYS_LEAP + DAYS_COMMON)) begin
            n_yic5      = 2'd1;
            n_doy5_wide = r_doc4 - 11'(DAYS_LEAP);
            n_leap5     = 1'b0;
        end else if (r_doc4 < 11'(DAYS_LEAP + 2 * DAYS_COMMON)) begin
            n_yic5      = 2'd2;
            n_doy5_wide = r_doc4 - 11'(DAYS_LEAP + DAYS_COMMON);
            n_leap5     = 1'b0;
        end else begin
            n_yic5      = 2'd3;
            n_doy5_wide = r_doc4 - 11'(DAYS_LEAP + 2 * DAYS_COMMON);
            n_leap5     = 1'b0;
        end
    end

    // Stage 6: month search over the start table, then BCD packing.
    always_comb begin
        n_month6 = 4'(MONTH_LAST);
        n_base6  = month_start(r_leap5, 4'(MONTH_LAST - 1));
        for (int m = MONTH_LAST; m >= MONTH_FIRST; m--) begin
            if (r_doy5 < month_start(r_leap5, 4'(m))) begin
                n_month6 = 4'(m);
                n_base6  = month_start(r_leap5, 4'(m - 1));
            end
        end
        n_dom6_wide = r_doy5 - n_base6 + 9'd1;
        n_min_bcd6  = to_bcd(7'(r_min5));
        n_hour_bcd6 = to_bcd(7'(r_hour5));
        n_day_bcd6  = to_bcd(n_dom6_wide[6:0]);
    end

    // Payload registers along the pipeline.
    always_ff @(posedge i_clk) begin
        r_secs0        <= i_seconds_since_2000;
        r_secs1        <= r_secs0;
        r_q1           <= n_q1;
        r_days2        <= n_days2;
        r_sod2         <= n_sod2;
        r_days3        <= r_days2;
        r_sod3         <= r_sod2;
        r_hour3        <= n_hprod3[31:HOUR_RECIP_K];
        r_cyc3         <= n_cprod3[31:CYC_RECIP_K];
        r_soh4         <= n_soh4_wide[11:0];
        r_doc4         <= n_doc4_wide[10:0];
        r_hour4        <= r_hour3;
        r_cyc4         <= r_cyc3;
        r_min5         <= n_mprod5[23:MIN_RECIP_K];
        r_hour5        <= r_hour4;
        r_year5        <= {r_cyc4, n_yic5};
        r_doy5         <= n_doy5_wide[8:0];
        r_leap5        <= n_leap5;
        o_minute_bcd   <= n_min_bcd6[6:0];
        o_hour_bcd     <= n_hour_bcd6[5:0];
        o_day_bcd      <= n_day_bcd6[5:0];
        o_month_number <= n_month6;
        o_year_offset  <= r_year5;
    end

endmodule

/* design/seccal_checker.sv */
// Port-level checker for the calendar alarm converter, bound to the top level.
// Depends on seccal_pkg and seconds_to_calendar_alarm_top_macros.svh.
`timescale 1ns / 1ps
`include "seconds_to_calendar_alarm_top_macros.svh"

module seccal_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input seccal_pkg::t_secs       i_seconds_since_2000,
    input logic                    o_done,
    input seccal_pkg::t_minute_bcd o_minute_bcd,
    input seccal_pkg::t_hour_bcd   o_hour_bcd,
    input seccal_pkg::t_day_bcd    o_day_bcd,
    input seccal_pkg::t_month      o_month_number,
    input seccal_pkg::t_year       o_year_offset
);
    import seccal_pkg::*;

    // The converter never holds off a transaction.
    `SCA_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !busy)

    // Every accepted transaction gives its result on o_done.
    `SCA_ASSERT_IMPLY(a_latency, i_clk, i_rst_n, start && !busy, ##7 o_done)

    // No result appears without an accepted transaction behind it.
    `SCA_ASSERT_IMPLY(a_no_spurious, i_clk, i_rst_n, o_done, $past(start, 7) && !$past(busy, 7))

    // Reset flushes the pipeline.
    `SCA_ASSERT_NEXT(a_reset_flush, i_clk, !i_rst_n, !o_done)

    // Month, minute ones digit, day and year offset stay in their calendar ranges.
    `SCA_ASSERT_IMPLY(a_field_range, i_clk, i_rst_n, o_done, (o_month_number >= 4'(MONTH_FIRST)) && (o_month_number <= 4'(MONTH_LAST)) && (o_minute_bcd[3:0] <= 4'd9) && (o_day_bcd != '0) && (o_year_offset <= 8'd136))

endmodule

bind seconds_to_calendar_alarm_top seccal_checker u_seccal_checker (.*);

/* tb/seconds_to_calendar_alarm_top_tb.sv */
// Self-checking testbench for seconds_to_calendar_alarm_top: a directed table, then random seconds.
// Depends on seccal_pkg for the port types and on the top level; it needs nothing else.
`timescale 1ns / 1ps

module seconds_to_calendar_alarm_top_tb;

    // Alarm fields of one result transaction, in port order.
    typedef struct packed {
        seccal_pkg::t_minute_bcd minute;
        seccal_pkg::t_hour_bcd   hour;
        seccal_pkg::t_day_bcd    day;
        seccal_pkg::t_month      month;
        seccal_pkg::t_year       year;
    } alarm_t;

    // One row of the directed table; want is used only where fixed is set.
    typedef struct packed {
        logic [31:0] secs;
        logic        fixed;
        alarm_t      want;
    } stim_row_t;

    localparam int unsigned SECS_IN_DAY  = 86400;
    localparam int unsigned DAYS_IN_QUAD = 1461;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          NUM_PHASES   = 3;

    // First day of months 1 to 12, counted from 0.
    localparam int unsigned COMMON_FIRST_DAY [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    localparam int unsigned LEAP_FIRST_DAY [12] =
        '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};
    // First day of each year within a four-year cycle.
    localparam int unsigned YEAR_FIRST_DAY [4] = '{0, 366, 731, 1096};

    // Random phases: sender idle percentage and transaction count.
    localparam int PHASE_IDLE_PCT [NUM_PHASES] = '{30, 79, 0};
    localparam int PHASE_ITEMS    [NUM_PHASES] = '{600, 600, 550};

    localparam int NUM_DIRECTED = 25;

    // Extremes of the input, time-of-day rollovers, month and year boundaries,
    // the leap day, and the leap-year index of exactly 365.
    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        '{32'd0,          1'b1, '{7'h00, 6'h00, 6'h01, 4'd1, 8'd0}},
        '{32'd59,         1'b1, '{7'h00, 6'h00, 6'h01, 4'd1, 8'd0}},
        '{32'd60,         1'b1, '{7'h01, 6'h00, 6'h01, 4'd1, 8'd0}},
        '{32'd3599,       1'b1, '{7'h59, 6'h00, 6'h01, 4'd1, 8'd0}},
        '{32'd3600,       1'b1, '{7'h00, 6'h01, 6'h01, 4'd1, 8'd0}},
        '{32'd86399,      1'b1, '{7'h59, 6'h23, 6'h01, 4'd1, 8'd0}},
        '{32'd86400,      1'b1, '{7'h00, 6'h00, 6'h02, 4'd1, 8'd0}},
        '{32'd45240,      1'b1, '{7'h34, 6'h12, 6'h01, 4'd1, 8'd0}},
        '{32'hFFFF_FFFF,  1'b1, '{7'h28, 6'h06, 6'h06, 4'd2, 8'd136}},
        '{32'(31 * SECS_IN_DAY),   1'b0, '0},
        '{32'(59 * SECS_IN_DAY),   1'b0, '0},
        '{32'(60 * SECS_IN_DAY),   1'b0, '0},
        '{32'(334 * SECS_IN_DAY),  1'b0, '0},
        '{32'(365 * SECS_IN_DAY),  1'b0, '0},
        '{32'(366 * SECS_IN_DAY),  1'b0, '0},
        '{32'(424 * SECS_IN_DAY),  1'b0, '0},
        '{32'(425 * SECS_IN_DAY),  1'b0, '0},
        '{32'(730 * SECS_IN_DAY),  1'b0, '0},
        '{32'(731 * SECS_IN_DAY),  1'b0, '0},
        '{32'(1095 * SECS_IN_DAY), 1'b0, '0},
        '{32'(1096 * SECS_IN_DAY), 1'b0, '0},
        '{32'(1460 * SECS_IN_DAY), 1'b0, '0},
        '{32'(1461 * SECS_IN_DAY), 1'b0, '0},
        '{32'(64'd49709 * 64'd86400 + 64'd86399), 1'b0, '0},
        '{32'h8000_0000,  1'b0, '0}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    seccal_pkg::t_secs         i_seconds_since_2000;
    logic                      o_done;
    seccal_pkg::t_minute_bcd   o_minute_bcd;
    seccal_pkg::t_hour_bcd     o_hour_bcd;
    seccal_pkg::t_day_bcd      o_day_bcd;
    seccal_pkg::t_month        o_month_number;
    seccal_pkg::t_year         o_year_offset;

    alarm_t pending_want;
    alarm_t pending_alarms [$];
    int     mismatch_count = 0;
    int     cycle_count = 0;
    int     sender_idle_pct = 0;

    seconds_to_calendar_alarm_top u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_seconds_since_2000 (i_seconds_since_2000),
        .o_done               (o_done),
        .o_minute_bcd         (o_minute_bcd),
        .o_hour_bcd           (o_hour_bcd),
        .o_day_bcd            (o_day_bcd),
        .o_month_number       (o_month_number),
        .o_year_offset        (o_year_offset)
    );

    // 20 ns clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Packed two-digit BCD of a value below 100.
    function automatic logic [7:0] packed_bcd(input int unsigned value);
        return 8'(((value / 10) << 4) | (value % 10));
    endfunction

    // Expected alarm fields for a count of seconds since the start of 2000.
    function automatic alarm_t calendar_of(input logic [31:0] secs);
        int unsigned total;
        int unsigned day_num;
        int unsigned day_in_year;
        int unsigned hour;
        int unsigned minute;
        int unsigned year;
        int unsigned month;
        int unsigned first_day;
        bit          leap;
        alarm_t      r;
        total   = secs;
        day_num = total / SECS_IN_DAY;
        hour    = (total % SECS_IN_DAY) / 3600;
        minute  = (total % 3600) / 60;
        year    = (day_num / DAYS_IN_QUAD) * 4;
        day_in_year = day_num % DAYS_IN_QUAD;
        leap    = (day_in_year < 366);
        // Strip the leading leap year, then whole common years.
        if (!leap) begin
            day_in_year -= 366;
            year++;
            while (day_in_year >= 365) begin
                day_in_year -= 365;
                year++;
            end
        end
        // The month is the last one whose first day is not past the index.
        month = 1;
        for (int m = 1; m < 12; m++) begin
            first_day = leap ? LEAP_FIRST_DAY[m] : COMMON_FIRST_DAY[m];
            if (day_in_year >= first_day) begin
                month = m + 1;
            end
        end
        first_day = leap ? LEAP_FIRST_DAY[month - 1] : COMMON_FIRST_DAY[month - 1];
        r.minute = 7'(packed_bcd(minute));
        r.hour   = 6'(packed_bcd(hour));
        r.day    = 6'(packed_bcd(day_in_year - first_day + 1));
        r.month  = 4'(month);
        r.year   = 8'(year);
        return r;
    endfunction

    // Random seconds: plain 32-bit values, times near day rollovers,
    // days near month and year boundaries, and the first four-year cycle.
    function automatic logic [31:0] random_seconds();
        longint unsigned day_num;
        longint unsigned tod;
        int              off;
        int              y;
        int              mi;
        int              mode;
        mode = $urandom_range(0, 99);
        tod  = $urandom_range(0, SECS_IN_DAY - 1);
        if (mode < 25) begin
            return $urandom;
        end else if (mode < 60) begin
            day_num = $urandom_range(0, 49709);
            case ($urandom_range(0, 7))
                0: tod = 0;
                1: tod = 59;
                2: tod = 60;
                3: tod = 3599;
                4: tod = 3600;
                5: tod = 86340;
                6: tod = 86399;
                default: ;
            endcase
            return 32'(day_num * SECS_IN_DAY + tod);
        end else if (mode < 90) begin
            y   = $urandom_range(0, 3);
            mi  = $urandom_range(0, 11);
            off = YEAR_FIRST_DAY[y] + ((y == 0) ? LEAP_FIRST_DAY[mi] : COMMON_FIRST_DAY[mi]);
            off = off - int'($urandom_range(0, 1));
            day_num = longint'($urandom_range(0, 33)) * DAYS_IN_QUAD;
            if (off < 0 && day_num == 0) begin
                off = 0;
            end
            day_num = 64'(longint'(day_num) + off);
            return 32'(day_num * SECS_IN_DAY + tod);
        end else begin
            return $urandom_range(0, DAYS_IN_QUAD * SECS_IN_DAY - 1);
        end
    endfunction

    // Offer one transaction, with random idle cycles first, and hold it until taken.
    task automatic send_seconds(input logic [31:0] secs, input alarm_t want);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start = 1'b0;
            i_seconds_since_2000 = $urandom;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_seconds_since_2000 = secs;
        pending_want = want;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_alarms.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Record accepted transactions and check each result against the oldest expectation.
    always @(posedge i_clk) begin : monitor
        alarm_t want;
        if (i_rst_n && start && !busy) begin
            pending_alarms.push_back(pending_want);
        end
        if (i_rst_n && o_done) begin
            if (pending_alarms.size() == 0) begin
                $error("result transaction with no expectation pending");
                mismatch_count++;
            end else begin
                want = pending_alarms.pop_front();
                check_field("minute_bcd", want.minute, o_minute_bcd);
                check_field("hour_bcd", want.hour, o_hour_bcd);
                check_field("day_bcd", want.day, o_day_bcd);
                check_field("month_number", want.month, o_month_number);
                check_field("year_offset", want.year, o_year_offset);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus: reset, the directed table, then three random phases.
    initial begin
        logic [31:0] secs;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_seconds_since_2000 = '0;
        pending_want = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        sender_idle_pct = PHASE_IDLE_PCT[0];
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_seconds(DIRECTED[i].secs,
                         DIRECTED[i].fixed ? DIRECTED[i].want : calendar_of(DIRECTED[i].secs));
        end
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            sender_idle_pct = PHASE_IDLE_PCT[p];
            for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
                secs = random_seconds();
                send_seconds(secs, calendar_of(secs));
            end
            // The sender holds off between phases until all results are in.
            drain_results();
        end

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/seccal_pkg.sv
design/seconds_to_calendar_alarm_top.sv
design/seccal_checker.sv
tb/seconds_to_calendar_alarm_top_tb.sv
